FILE: rtl/core/fat32des_pkg.sv
`default_nettype none

package fat32des_pkg;

   // one input transfer: a byte of raw directory data plus scan markers
   typedef struct packed {
      logic [7:0] entry_byte;
      logic       scan_start;
      logic       scan_end;
   } req_type;

   // one result transfer
   typedef struct packed {
      logic        search_status;
      logic [7:0]  attributes;
      logic [31:0] start_cluster;
      logic [31:0] file_size;
   } rsp_type;

   // configured 8.3 name, first character in the low byte
   typedef struct packed {
      logic [23:0] name_ext;
      logic [63:0] name_base;
   } cfg_type;

   // result from the scanner, valid for the transfer being taken this cycle
   typedef struct packed {
      logic    valid;
      rsp_type data;
   } scan_res_type;

   localparam int OffsetWidth = 5;

   localparam logic [7:0] EntryEndMark     = 8'h00;
   localparam logic [7:0] EntryDeletedMark = 8'hE5;
   localparam logic [3:0] LongNameAttr     = 4'hF;

   localparam logic [OffsetWidth-1:0] OffFirst     = 5'd0;
   localparam logic [OffsetWidth-1:0] NameLen      = 5'd11;
   localparam logic [OffsetWidth-1:0] OffAttr      = 5'd11;
   localparam logic [OffsetWidth-1:0] OffClusterHi = 5'd20;
   localparam logic [OffsetWidth-1:0] OffClusterHx = 5'd21;
   localparam logic [OffsetWidth-1:0] OffClusterLo = 5'd26;
   localparam logic [OffsetWidth-1:0] OffClusterLx = 5'd27;
   localparam logic [OffsetWidth-1:0] OffSize      = 5'd28;
   localparam logic [OffsetWidth-1:0] OffLast      = 5'd31;

   localparam logic StatusFound    = 1'b0;
   localparam logic StatusNotFound = 1'b1;

   // register index as decoded from the byte address
   localparam logic RegNameBase = 1'b0;
   localparam logic RegNameExt  = 1'b1;

   localparam logic [63:0] NameBaseReset = 64'h2020_2020_2020_2020;
   localparam logic [23:0] NameExtReset  = 24'h20_2020;

endpackage

`default_nettype wire

FILE: rtl/core/fat32des_scan.sv
`default_nettype none

module fat32des_scan
   import fat32des_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         take,
   input  wire req_type      req,
   input  wire cfg_type      cfg,
   output scan_res_type      res
);

   logic [OffsetWidth-1:0] offset_ff, offset_in;
   logic                   equal_ff, equal_in;
   logic                   skip_ff, skip_in;
   logic                   done_ff, done_in;
   logic [7:0]             attr_ff, attr_in;
   logic [15:0]            clus_hi_ff, clus_hi_in;
   logic [15:0]            clus_lo_ff, clus_lo_in;
   logic [31:0]            size_ff, size_in;

   logic [OffsetWidth-1:0] off;
   logic                   eff_equal;
   logic                   eff_skip;
   logic                   eff_done;
   logic [87:0]            name_chars;
   logic [7:0]             name_char;
   logic [7:0]             b;
   logic                   dir_end;
   logic                   match;

   assign b          = req.entry_byte;
   // scan_start clears the search before this byte is looked at
   assign off        = req.scan_start ? OffFirst : offset_ff;
   assign eff_equal  = req.scan_start ? 1'b1 : equal_ff;
   assign eff_skip   = req.scan_start ? 1'b0 : skip_ff;
   assign eff_done   = req.scan_start ? 1'b0 : done_ff;
   assign name_chars = {cfg.name_ext, cfg.name_base};

   always_comb begin
      if (off < NameLen) begin
         name_char = name_chars[{off[3:0], 3'b000} +: 8];
      end else begin
         name_char = 8'h00;
      end
   end

   assign dir_end = (off == OffFirst) && (b == EntryEndMark);

   always_comb begin
      offset_in  = off;
      equal_in   = eff_equal;
      skip_in    = eff_skip;
      done_in    = eff_done;
      attr_in    = attr_ff;
      clus_hi_in = clus_hi_ff;
      clus_lo_in = clus_lo_ff;
      size_in    = size_ff;
      match      = 1'b0;
      if (!eff_done) begin
         if (dir_end) begin
            done_in = 1'b1;
         end else begin
            if (off == OffFirst) begin
               equal_in = 1'b1;
               skip_in  = (b == EntryDeletedMark);
            end
            if (off < NameLen && b != name_char) begin
               equal_in = 1'b0;
            end
            if (off == OffAttr) begin
               attr_in = b;
               if (b[3:0] == LongNameAttr) begin
                  skip_in = 1'b1;
               end
            end
            if (off == OffClusterHi) clus_hi_in[7:0]  = b;
            if (off == OffClusterHx) clus_hi_in[15:8] = b;
            if (off == OffClusterLo) clus_lo_in[7:0]  = b;
            if (off == OffClusterLx) clus_lo_in[15:8] = b;
            if (off >= OffSize) begin
               size_in[{off[1:0], 3'b000} +: 8] = b;
            end
            offset_in = off + 1'b1;
            match     = (off == OffLast) && equal_in && !skip_in;
            done_in   = match || req.scan_end;
         end
      end
   end

   always_comb begin
      res.valid              = take && !eff_done && (dir_end || match || req.scan_end);
      res.data.search_status = match ? StatusFound : StatusNotFound;
      res.data.attributes    = match ? attr_ff : 8'h00;
      res.data.start_cluster = match ? {clus_hi_ff, clus_lo_ff} : 32'h0;
      res.data.file_size     = match ? size_in : 32'h0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= OffFirst;
         equal_ff  <= 1'b1;
         skip_ff   <= 1'b0;
         done_ff   <= 1'b0;
      end else if (take) begin
         offset_ff <= offset_in;
         equal_ff  <= equal_in;
         skip_ff   <= skip_in;
         done_ff   <= done_in;
      end
   end

   // entry fields are always rewritten before a match can report them
   always_ff @(posedge clock) begin
      if (take) begin
         attr_ff    <= attr_in;
         clus_hi_ff <= clus_hi_in;
         clus_lo_ff <= clus_lo_in;
         size_ff    <= size_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/fat32_directory_entry_search.sv
// fat32 directory entry search
//
// req channel: one byte of raw directory data per transfer, in order, with
// scan_start on byte 0 of a new search and scan_end on the last byte.
// rsp channel: at most one result per search (found with attributes,
// first cluster and size, or not found with zero fields).
// config: name_base at byte address 0, name_ext at address 8 (64-bit data);
// the user writes it only while no search result is pending, unenforced here.
//
// throughput: one byte per cycle while req_stall is low; each byte is handled
// in the cycle it is taken and its result is registered in the result buffer.
// a two-entry result buffer (output register plus skid register) parts the
// two channels: req_stall rises only once both entries hold a result while
// rsp is stalled, and falls the cycle after the receiver takes one.
// reset clears the scan state and result buffer and loads a blank name of
// spaces; bytes are taken from the first cycle after reset.
`default_nettype none

module fat32_directory_entry_search
   import fat32des_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // input channel
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire req_type     req_data,
   // result channel
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      rsp_type     rsp_data,
   // configuration port
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [63:0] pwdata,
   output      logic [63:0] prdata,
   output      logic        pready
);

   cfg_type      cfg_ff;
   scan_res_type res;
   logic         req_take;
   logic         rsp_take;
   logic         csr_write;

   logic         out_valid_ff;
   rsp_type      out_data_ff;
   logic         skid_valid_ff;
   rsp_type      skid_data_ff;

   // ---- configuration registers
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.name_base <= NameBaseReset;
         cfg_ff.name_ext  <= NameExtReset;
      end else if (csr_write) begin
         unique case (paddr[3])
            RegNameBase: cfg_ff.name_base <= pwdata;
            RegNameExt:  cfg_ff.name_ext  <= pwdata[23:0];
            default:     cfg_ff.name_base <= cfg_ff.name_base;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3])
         RegNameBase: prdata = cfg_ff.name_base;
         RegNameExt:  prdata = {40'h0, cfg_ff.name_ext};
         default:     prdata = 64'h0;
      endcase
   end

   // ---- byte scanner
   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && !req_stall;

   fat32des_scan u_scan (
      .clock (clock),
      .reset (reset),
      .take  (req_take),
      .req   (req_data),
      .cfg   (cfg_ff),
      .res   (res)
   );

   // ---- result buffer: output register with a skid entry behind it
   assign rsp_take = out_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         // no req transfer while the skid entry is full
         if (rsp_take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (res.valid) begin
         if (out_valid_ff && !rsp_take) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (rsp_take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_take) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (res.valid) begin
         if (out_valid_ff && !rsp_take) begin
            skid_data_ff <= res.data;
         end else begin
            out_data_ff <= res.data;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // ---- checks
   // the skid entry only fills behind a held output register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry full while output register empty");

   // the scanner never produces a result with nowhere to put it
   a_no_result_when_full: assert property (@(posedge clock) disable iff (reset)
      !(skid_valid_ff && res.valid))
      else $error("result produced while result buffer full");

   // a not-found result carries all-zero fields
   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.search_status == StatusNotFound) |->
      (rsp_data.attributes == 8'h0 && rsp_data.start_cluster == 32'h0 &&
       rsp_data.file_size == 32'h0))
      else $error("not-found result with nonzero fields");

endmodule

`default_nettype wire
